// ===== rtl/core/sfr_pkg.sv =====
package sfr_pkg;

  localparam int BYTE_W    = 8;
  localparam int CFG_W     = 64;
  localparam int LEN_W     = 4;
  localparam int CFG_IDX_W = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PATTERN_BYTES     = 2'd0,
    REG_PATTERN_LENGTH    = 2'd1,
    REG_SUBSTITUTE_BYTES  = 2'd2,
    REG_SUBSTITUTE_LENGTH = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic [LEN_W-1:0] len;
    logic             final_flag;
  } run_ctl_t;

endpackage

// ===== rtl/core/sfr_if.sv =====
interface sfr_in_if;
  logic                      valid;
  logic                      ready;
  logic [sfr_pkg::BYTE_W-1:0] in_byte;
  logic                      in_final;

  modport source (output valid, output in_byte, output in_final, input ready);
  modport sink   (input valid, input in_byte, input in_final, output ready);
endinterface

interface sfr_out_if;
  logic                      valid;
  logic                      ready;
  logic [sfr_pkg::BYTE_W-1:0] out_byte;
  logic                      byte_present;
  logic                      run_last;
  logic                      stream_last;

  modport source (output valid, output out_byte, output byte_present, output run_last,
                  output stream_last, input ready);
  modport sink   (input valid, input out_byte, input byte_present, input run_last,
                  input stream_last, output ready);
endinterface

// ===== rtl/core/sfr_window.sv =====
module sfr_window #(
  parameter int MAX_PATTERN    = 8,
  parameter int MAX_SUBSTITUTE = 8,
  parameter int RUN_DEPTH      = 8
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  accept,
  input  logic [sfr_pkg::BYTE_W-1:0]            in_byte,
  input  logic                                  in_final,
  input  logic [sfr_pkg::CFG_W-1:0]             pattern_bytes,
  input  logic [sfr_pkg::LEN_W-1:0]             pattern_length,
  input  logic [sfr_pkg::CFG_W-1:0]             substitute_bytes,
  input  logic [sfr_pkg::LEN_W-1:0]             substitute_length,
  input  logic                                  plen_wr,
  output logic [RUN_DEPTH*sfr_pkg::BYTE_W-1:0]  run_bytes,
  output sfr_pkg::run_ctl_t                     run_ctl
);

  localparam int BW = sfr_pkg::BYTE_W;
  localparam int LW = sfr_pkg::LEN_W;

  logic [BW-1:0] win_r   [MAX_PATTERN];
  logic [BW-1:0] win_nxt [MAX_PATTERN];
  logic [BW-1:0] win_w   [MAX_PATTERN];
  logic [LW-1:0] fill_r, fill_nxt;

  logic [LW-1:0] plen, slen, fill0, fill1, run_len;
  logic          full, match, hit;

  // effective lengths
  always_comb begin
    if (pattern_length == '0) begin
      plen = LW'(1);
    end else if (pattern_length > LW'(MAX_PATTERN)) begin
      plen = LW'(MAX_PATTERN);
    end else begin
      plen = pattern_length;
    end
    if (substitute_length > LW'(MAX_SUBSTITUTE)) begin
      slen = LW'(MAX_SUBSTITUTE);
    end else begin
      slen = substitute_length;
    end
  end

  // insert the new byte and compare
  always_comb begin
    fill0 = (fill_r >= plen) ? '0 : fill_r;
    for (int i = 0; i < MAX_PATTERN; i++) begin
      win_w[i] = (fill0 == LW'(i)) ? in_byte : win_r[i];
    end
    fill1 = fill0 + LW'(1);
    full  = (fill1 == plen);
    match = 1'b1;
    for (int i = 0; i < MAX_PATTERN; i++) begin
      if ((LW'(i) < plen) && (win_w[i] != pattern_bytes[BW*i +: BW])) begin
        match = 1'b0;
      end
    end
    hit = full && match;
  end

  // run contents for the output stage
  always_comb begin
    for (int i = 0; i < RUN_DEPTH; i++) begin
      if (hit) begin
        run_bytes[BW*i +: BW] = substitute_bytes[BW*i +: BW];
      end else if (i < MAX_PATTERN) begin
        run_bytes[BW*i +: BW] = win_w[i];
      end else begin
        run_bytes[BW*i +: BW] = '0;
      end
    end
    if (hit) begin
      run_len = slen;
    end else if (in_final) begin
      run_len = fill1;
    end else if (full) begin
      run_len = LW'(1);
    end else begin
      run_len = '0;
    end
    run_ctl.len        = run_len;
    run_ctl.final_flag = in_final;
  end

  // window update
  always_comb begin
    fill_nxt = fill_r;
    for (int i = 0; i < MAX_PATTERN; i++) begin
      win_nxt[i] = win_r[i];
    end
    if (plen_wr) begin
      fill_nxt = '0;
    end else if (accept) begin
      if (hit || in_final) begin
        fill_nxt = '0;
      end else if (full) begin
        fill_nxt = plen - LW'(1);
      end else begin
        fill_nxt = fill1;
      end
      for (int i = 0; i < MAX_PATTERN; i++) begin
        if (full && !hit) begin
          win_nxt[i] = (i < MAX_PATTERN - 1) ? win_w[(i + 1) % MAX_PATTERN] : win_w[i];
        end else begin
          win_nxt[i] = win_w[i];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
    end else begin
      fill_r <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < MAX_PATTERN; i++) begin
      win_r[i] <= win_nxt[i];
    end
  end

endmodule

// ===== rtl/core/sfr_serializer.sv =====
module sfr_serializer #(
  parameter int RUN_DEPTH = 8
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 load_valid,
  output logic                                 load_ready,
  input  logic [RUN_DEPTH*sfr_pkg::BYTE_W-1:0] run_bytes,
  input  sfr_pkg::run_ctl_t                    run_ctl,
  sfr_out_if.source                            out_ch
);

  localparam int BW = sfr_pkg::BYTE_W;
  localparam int LW = sfr_pkg::LEN_W;

  logic [BW-1:0] bytes_r [RUN_DEPTH];
  logic [LW-1:0] rem_r, rem_nxt;
  logic          present_r, final_r;
  logic          last, take, load;

  assign last       = (rem_r == LW'(1));
  assign take       = out_ch.valid && out_ch.ready;
  assign load_ready = (rem_r == '0) || (take && last);
  // runs with no beat and no end marker are dropped
  assign load       = load_valid && load_ready && ((run_ctl.len != '0) || run_ctl.final_flag);

  assign out_ch.valid        = (rem_r != '0);
  assign out_ch.out_byte     = present_r ? bytes_r[0] : '0;
  assign out_ch.byte_present = present_r;
  assign out_ch.run_last     = last;
  assign out_ch.stream_last  = last && final_r;

  always_comb begin
    rem_nxt = rem_r;
    if (load) begin
      rem_nxt = (run_ctl.len != '0) ? run_ctl.len : LW'(1);
    end else if (take) begin
      rem_nxt = rem_r - LW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rem_r <= '0;
    end else begin
      rem_r <= rem_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      for (int i = 0; i < RUN_DEPTH; i++) begin
        bytes_r[i] <= run_bytes[BW*i +: BW];
      end
      present_r <= (run_ctl.len != '0);
      final_r   <= run_ctl.final_flag;
    end else if (take) begin
      for (int i = 0; i < RUN_DEPTH - 1; i++) begin
        bytes_r[i] <= bytes_r[i + 1];
      end
    end
  end

endmodule

// ===== rtl/core/stream_find_replace_top.sv =====
// an item's first result beat is registered and valid in the cycle after the item beat
// throughput: one item per cycle while items yield at most one result beat and out_ch
// is ready; a longer run holds input until the output run register sends its last beat
// reset: synchronous active-low rst_n clears the window fill, the output run
// and the configuration registers (pattern length 1, everything else zero)
module stream_find_replace_top #(
  parameter int MAX_PATTERN    = 8,
  parameter int MAX_SUBSTITUTE = 8
) (
  input  logic                            clk,
  input  logic                            rst_n,
  sfr_in_if.sink                          in_ch,
  sfr_out_if.source                       out_ch,
  input  logic                            cfg_we,
  input  logic [sfr_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [sfr_pkg::CFG_W-1:0]       cfg_data
);

  localparam int LW        = sfr_pkg::LEN_W;
  localparam int RUN_DEPTH = (MAX_PATTERN > MAX_SUBSTITUTE) ? MAX_PATTERN : MAX_SUBSTITUTE;

  logic [sfr_pkg::CFG_W-1:0]             pattern_bytes_r, substitute_bytes_r;
  logic [LW-1:0]                         pattern_length_r, substitute_length_r;
  logic                                  plen_wr, accept, run_ready;
  logic [RUN_DEPTH*sfr_pkg::BYTE_W-1:0]  run_bytes;
  sfr_pkg::run_ctl_t                     run_ctl;

  assign plen_wr     = cfg_we && (cfg_index == sfr_pkg::REG_PATTERN_LENGTH);
  assign in_ch.ready = run_ready;
  assign accept      = in_ch.valid && run_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pattern_bytes_r     <= '0;
      pattern_length_r    <= LW'(1);
      substitute_bytes_r  <= '0;
      substitute_length_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        sfr_pkg::REG_PATTERN_BYTES:     pattern_bytes_r     <= cfg_data;
        sfr_pkg::REG_PATTERN_LENGTH:    pattern_length_r    <= cfg_data[LW-1:0];
        sfr_pkg::REG_SUBSTITUTE_BYTES:  substitute_bytes_r  <= cfg_data;
        sfr_pkg::REG_SUBSTITUTE_LENGTH: substitute_length_r <= cfg_data[LW-1:0];
        default: begin
        end
      endcase
    end
  end

  sfr_window #(
    .MAX_PATTERN    (MAX_PATTERN),
    .MAX_SUBSTITUTE (MAX_SUBSTITUTE),
    .RUN_DEPTH      (RUN_DEPTH)
  ) u_window (
    .clk               (clk),
    .rst_n             (rst_n),
    .accept            (accept),
    .in_byte           (in_ch.in_byte),
    .in_final          (in_ch.in_final),
    .pattern_bytes     (pattern_bytes_r),
    .pattern_length    (pattern_length_r),
    .substitute_bytes  (substitute_bytes_r),
    .substitute_length (substitute_length_r),
    .plen_wr           (plen_wr),
    .run_bytes         (run_bytes),
    .run_ctl           (run_ctl)
  );

  sfr_serializer #(
    .RUN_DEPTH (RUN_DEPTH)
  ) u_serializer (
    .clk        (clk),
    .rst_n      (rst_n),
    .load_valid (in_ch.valid),
    .load_ready (run_ready),
    .run_bytes  (run_bytes),
    .run_ctl    (run_ctl),
    .out_ch     (out_ch)
  );

  a_no_beat_after_reset: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_ch.valid)
    else $error("result beat right after reset");

  a_accept_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && out_ch.valid) |-> (out_ch.ready && out_ch.run_last))
    else $error("new item taken before pending run finished");

  a_bare_marker: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && !out_ch.byte_present) |->
      (out_ch.stream_last && out_ch.run_last && out_ch.out_byte == '0))
    else $error("bare end marker malformed");

  a_hold_while_stalled: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && !out_ch.ready) |=>
      (out_ch.valid && $stable(out_ch.out_byte) && $stable(out_ch.byte_present) &&
       $stable(out_ch.run_last) && $stable(out_ch.stream_last)))
    else $error("result beat changed while stalled");

endmodule

// ===== dv/tb_stream_find_replace_top.sv =====
module tb_stream_find_replace_top;

  localparam int MAX_PAT     = 8;
  localparam int MAX_SUB     = 8;
  localparam int LIMIT       = 300000;
  localparam int PAUSE_EVERY = 97;
  localparam int PHASES      = 12;
  localparam int PHASE_ITEMS = 34;

  typedef struct packed {
    logic [sfr_pkg::BYTE_W-1:0] ch;
    logic                       fin;
  } text_item_t;

  typedef struct packed {
    logic [sfr_pkg::BYTE_W-1:0] ch;
    logic                       present;
    logic                       run_end;
    logic                       stream_end;
  } edit_beat_t;

  logic                      clk;
  logic                      rst_n;
  logic                      cfg_we;
  sfr_pkg::cfg_reg_t         cfg_index;
  logic [sfr_pkg::CFG_W-1:0] cfg_data;

  sfr_in_if  in_ch ();
  sfr_out_if out_ch ();

  stream_find_replace_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // predictor copy of the registers and the match window
  logic [sfr_pkg::CFG_W-1:0]  pat_bytes = '0;
  logic [sfr_pkg::LEN_W-1:0]  pat_len   = 4'd1;
  logic [sfr_pkg::CFG_W-1:0]  sub_bytes = '0;
  logic [sfr_pkg::LEN_W-1:0]  sub_len   = '0;
  logic [sfr_pkg::BYTE_W-1:0] win [MAX_PAT];
  int                         win_fill  = 0;

  text_item_t                 byte_q [$];
  edit_beat_t                 edited_q [$];
  logic [sfr_pkg::BYTE_W-1:0] abc [3];

  int offered      = 0;
  int taken        = 0;
  int beats_seen   = 0;
  int stream_ends  = 0;
  int pattern_hits = 0;
  int regs_written = 0;
  int errors       = 0;
  int cycle_cnt    = 0;
  int send_idle    = 34;
  int recv_idle    = 45;
  bit hold_in      = 1'b0;

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  function automatic int eff_pat_len(input logic [sfr_pkg::LEN_W-1:0] v);
    if (v == 0) return 1;
    if (v > MAX_PAT) return MAX_PAT;
    return int'(v);
  endfunction

  task automatic edit_byte(input logic [sfr_pkg::BYTE_W-1:0] b, input logic fin);
    edit_beat_t run_buf [16];
    int         n;
    int         plen;
    int         slen;
    bit         hit;
    n = 0;
    plen = eff_pat_len(pat_len);
    slen = (sub_len > MAX_SUB) ? MAX_SUB : int'(sub_len);
    if (win_fill >= plen) win_fill = 0;
    win[win_fill & (MAX_PAT - 1)] = b;
    win_fill++;
    if (win_fill == plen) begin
      hit = 1'b1;
      for (int i = 0; i < plen; i++) begin
        if (win[i] != pat_bytes[8*i +: 8]) hit = 1'b0;
      end
      if (hit) begin
        for (int i = 0; i < slen; i++) begin
          run_buf[n] = '{sub_bytes[8*i +: 8], 1'b1, 1'b0, 1'b0};
          n++;
        end
        win_fill = 0;
        pattern_hits++;
      end else begin
        run_buf[n] = '{win[0], 1'b1, 1'b0, 1'b0};
        n++;
        for (int i = 1; i < plen; i++) win[i-1] = win[i];
        win_fill = plen - 1;
      end
    end
    if (fin) begin
      for (int i = 0; i < win_fill; i++) begin
        run_buf[n] = '{win[i], 1'b1, 1'b0, 1'b0};
        n++;
      end
      win_fill = 0;
      // bare end marker
      if (n == 0) begin
        run_buf[0] = '0;
        n = 1;
      end
      run_buf[n-1].stream_end = 1'b1;
    end
    if (n > 0) run_buf[n-1].run_end = 1'b1;
    for (int i = 0; i < n; i++) edited_q.push_back(run_buf[i]);
  endtask

  // result check first, then the accepted input beat
  always @(posedge clk) begin : mon_blk
    edit_beat_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (edited_q.size() == 0) begin
        $error("unexpected result beat: out_byte %0h byte_present %0b", out_ch.out_byte,
               out_ch.byte_present);
        errors++;
      end else begin
        want = edited_q.pop_front();
        beats_seen++;
        if (out_ch.stream_last === 1'b1) stream_ends++;
        if (out_ch.out_byte !== want.ch) begin
          $error("out_byte: expected %0h, got %0h", want.ch, out_ch.out_byte);
          errors++;
        end
        if (out_ch.byte_present !== want.present) begin
          $error("byte_present: expected %0b, got %0b", want.present, out_ch.byte_present);
          errors++;
        end
        if (out_ch.run_last !== want.run_end) begin
          $error("run_last: expected %0b, got %0b", want.run_end, out_ch.run_last);
          errors++;
        end
        if (out_ch.stream_last !== want.stream_end) begin
          $error("stream_last: expected %0b, got %0b", want.stream_end, out_ch.stream_last);
          errors++;
        end
      end
    end
    if (rst_n && in_ch.valid && in_ch.ready) begin
      edit_byte(in_ch.in_byte, in_ch.in_final);
      taken++;
    end
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > LIMIT) begin
      $display("tb_stream_find_replace_top: errors");
      $finish;
    end
  end

  always @(negedge clk) begin : drive_blk
    text_item_t nxt;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (taken == offered) begin
      if (hold_in && edited_q.size() == 0) hold_in = 1'b0;
      if (byte_q.size() != 0 && !hold_in && $urandom_range(99) >= send_idle) begin
        nxt = byte_q.pop_front();
        in_ch.in_byte  <= nxt.ch;
        in_ch.in_final <= nxt.fin;
        in_ch.valid    <= 1'b1;
        offered++;
        // hold off until the output side has drained
        if (offered % PAUSE_EVERY == 0) hold_in = 1'b1;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    out_ch.ready <= rst_n && ($urandom_range(99) >= recv_idle);
  end

  task automatic push_text(input logic [sfr_pkg::BYTE_W-1:0] ch, input logic fin);
    text_item_t it;
    it.ch = ch;
    it.fin = fin;
    byte_q.push_back(it);
  endtask

  task automatic drain();
    while (byte_q.size() != 0 || taken != offered || edited_q.size() != 0) @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  task automatic write_reg(input sfr_pkg::cfg_reg_t idx,
                           input logic [sfr_pkg::CFG_W-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      sfr_pkg::REG_PATTERN_BYTES: pat_bytes = val;
      sfr_pkg::REG_PATTERN_LENGTH: begin
        pat_len = val[sfr_pkg::LEN_W-1:0];
        win_fill = 0;
      end
      sfr_pkg::REG_SUBSTITUTE_BYTES: sub_bytes = val;
      sfr_pkg::REG_SUBSTITUTE_LENGTH: sub_len = val[sfr_pkg::LEN_W-1:0];
      default: ;
    endcase
    regs_written++;
  endtask

  task automatic load_setting(input logic [sfr_pkg::LEN_W-1:0] pl,
                              input logic [sfr_pkg::CFG_W-1:0] pb,
                              input logic [sfr_pkg::LEN_W-1:0] sl,
                              input logic [sfr_pkg::CFG_W-1:0] sb);
    logic [sfr_pkg::CFG_W-1:0] junk;
    drain();
    write_reg(sfr_pkg::REG_PATTERN_BYTES, pb);
    junk = {$urandom(), $urandom()};
    junk[sfr_pkg::LEN_W-1:0] = pl;
    write_reg(sfr_pkg::REG_PATTERN_LENGTH, junk);
    write_reg(sfr_pkg::REG_SUBSTITUTE_BYTES, sb);
    junk = {$urandom(), $urandom()};
    junk[sfr_pkg::LEN_W-1:0] = sl;
    write_reg(sfr_pkg::REG_SUBSTITUTE_LENGTH, junk);
  endtask

  // text mostly from a small alphabet with the pattern dropped in, sometimes cut short
  task automatic queue_text(input int n);
    int                         made;
    int                         k;
    logic [sfr_pkg::BYTE_W-1:0] c;
    made = 0;
    while (made < n) begin
      if ($urandom_range(9) < 3) begin
        k = eff_pat_len(pat_len);
        if ($urandom_range(3) == 0) k = $urandom_range(k, 1);
        for (int i = 0; i < k; i++) push_text(pat_bytes[8*i +: 8], $urandom_range(15) == 0);
        made += k;
      end else begin
        c = ($urandom_range(4) == 0) ? 8'($urandom()) : abc[$urandom_range(2)];
        push_text(c, $urandom_range(11) == 0);
        made++;
      end
    end
    if ($urandom_range(1) == 0) push_text(abc[0], 1'b1);
  endtask

  initial begin
    logic [sfr_pkg::LEN_W-1:0] pl;
    logic [sfr_pkg::LEN_W-1:0] sl;
    logic [sfr_pkg::CFG_W-1:0] pb;
    logic [sfr_pkg::CFG_W-1:0] sb;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = sfr_pkg::REG_PATTERN_BYTES;
    cfg_data = '0;
    in_ch.valid = 1'b0;
    in_ch.in_byte = '0;
    in_ch.in_final = 1'b0;
    out_ch.ready = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // "ab" -> "XYZ", overlaps, partial match at the stream end
    load_setting(4'd2, 64'hA5A5_A5A5_A5A5_6261, 4'd3, 64'h0000_0000_005A_5958);
    push_text(8'h78, 1'b0);
    push_text(8'h61, 1'b0);
    push_text(8'h62, 1'b0);
    push_text(8'h61, 1'b0);
    push_text(8'h61, 1'b0);
    push_text(8'h62, 1'b0);
    push_text(8'h63, 1'b1);
    push_text(8'h61, 1'b1);
    push_text(8'h61, 1'b0);
    push_text(8'h62, 1'b1);

    // deletion leaves a bare end marker
    drain();
    write_reg(sfr_pkg::REG_SUBSTITUTE_LENGTH, 64'd0);
    push_text(8'h61, 1'b0);
    push_text(8'h62, 1'b1);

    // length rewrite drops the held bytes
    drain();
    write_reg(sfr_pkg::REG_PATTERN_BYTES, 64'h0000_0000_0063_6261);
    write_reg(sfr_pkg::REG_PATTERN_LENGTH, 64'd3);
    push_text(8'h61, 1'b0);
    push_text(8'h62, 1'b0);
    drain();
    write_reg(sfr_pkg::REG_PATTERN_LENGTH, 64'd3);
    push_text(8'h63, 1'b1);

    // length zero acts as one, oversize substitute length clamps
    load_setting(4'd0, 64'h0, 4'd15, 64'h0123_4567_89AB_CDEF);
    push_text(8'h00, 1'b0);
    push_text(8'hFF, 1'b0);
    push_text(8'h00, 1'b1);

    // oversize pattern length clamps to the full window
    load_setting(4'd15, '1, 4'd8, 64'hFEDC_BA98_7654_3210);
    for (int i = 0; i < MAX_PAT; i++) push_text(8'hFF, i == MAX_PAT - 1);

    for (int p = 0; p < PHASES; p++) begin
      if (p == PHASES / 3) begin
        send_idle = 45;
        recv_idle = 34;
      end
      if (p == 2 * PHASES / 3) begin
        send_idle = 0;
        recv_idle = 0;
      end
      for (int i = 0; i < 3; i++) abc[i] = 8'($urandom());
      case (p)
        0: pl = 4'd1;
        1: pl = 4'd8;
        2: pl = 4'd0;
        3: pl = 4'd15;
        default: pl = 4'($urandom_range(MAX_PAT, 1));
      endcase
      case (p)
        0: sl = 4'd8;
        1: sl = 4'd0;
        2: sl = 4'd15;
        3: sl = 4'd1;
        default: sl = 4'($urandom_range(MAX_SUB, 0));
      endcase
      pb = {$urandom(), $urandom()};
      for (int i = 0; i < eff_pat_len(pl); i++) pb[8*i +: 8] = abc[$urandom_range(2)];
      sb = {$urandom(), $urandom()};
      load_setting(pl, pb, sl, sb);
      queue_text(PHASE_ITEMS);
    end

    drain();
    repeat (10) @(negedge clk);
    $display("covered %0d input bytes, %0d result beats, %0d pattern hits, %0d stream ends",
             taken, beats_seen, pattern_hits, stream_ends);
    $display("over %0d register writes, lengths at both ends, three idle mixes", regs_written);
    if (errors == 0 && edited_q.size() == 0) begin
      $display("tb_stream_find_replace_top: clean");
    end else begin
      $display("tb_stream_find_replace_top: errors");
    end
    $finish;
  end

endmodule
